>>> rtl/skl_pkg.sv
// Package for the sorted key list: sizes, codes, payload and cell control types.
`default_nettype none

package skl_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_INSERT   = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef logic signed [KEY_WIDTH-1:0] key_t;

  typedef struct packed {
    logic [1:0] mode;
    key_t       key;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    key_t             key_out;
    logic [CNT_W-1:0] count;
  } result_t;

  // Per-cell move control for the update cycle
  typedef struct packed {
    logic wr;    // load the command key
    logic up;    // take the lower neighbor's key
    logic down;  // take the upper neighbor's key
  } cell_ctrl_t;

  localparam logic REG_ORDERED = 1'b0;

endpackage

`default_nettype wire

>>> rtl/skl_cell.sv
// One list cell: holds a key, compares it with the command key, moves with its neighbors.
`default_nettype none

module skl_cell (
  input  wire logic                 clk,
  input  wire logic                 cmp_en,
  input  wire logic                 valid,
  input  wire skl_pkg::key_t        cmd_key,
  input  wire skl_pkg::key_t        prev_key,
  input  wire skl_pkg::key_t        next_key,
  input  wire skl_pkg::cell_ctrl_t  ctrl,
  output skl_pkg::key_t             key,
  output logic                      eq,
  output logic                      gt
);

  skl_pkg::key_t key_next;

  // Priority: load, shift up, shift down, hold
  always_comb begin
    key_next = key;
    if (ctrl.wr) begin
      key_next = cmd_key;
    end else if (ctrl.up) begin
      key_next = prev_key;
    end else if (ctrl.down) begin
      key_next = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    if (cmp_en) begin
      eq <= valid && (key == cmd_key);
      gt <= valid && (key > cmd_key);
    end
  end

endmodule

`default_nettype wire

>>> rtl/sorted_key_list_core.sv
// Top level of the sorted key list: command port, APB register and the cell chain.
//
//   channel   handshake            payload
//   command   start / busy         cmd    (mode, key)
//   result    done (strobe)        result (status, position, key_out, count)
//   config    APB psel/penable     pwdata[0] -> ordered when paddr[2] is 0
//
// Each item passes an accept and an update cycle: in the accept cycle every cell
// compares its key with the command key and registers equal / greater flags;
// in the update cycle the first-match mask is formed with one DEPTH-bit add,
// the cells shift in one move and the result register loads. done pulses in the next
// cycle; start may be accepted again in that same cycle.
// rst clears the count, the ordered bit and the handshake; cell keys are not cleared.
// The receiver cannot stall: done is a one-cycle strobe; result holds until the next.
`default_nettype none

module sorted_key_list_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire skl_pkg::cmd_t    cmd,
  output logic                  done,
  output skl_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int N  = skl_pkg::DEPTH;
  localparam int PW = skl_pkg::POS_W;
  localparam int CW = skl_pkg::CNT_W;

  // ---------------------------------------------------------------- config
  logic ordered;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == skl_pkg::REG_ORDERED) ? {31'b0, ordered} : 32'b0;

  // ---------------------------------------------------------------- command
  logic           accept;
  skl_pkg::cmd_t  cmd_q;
  logic [CW-1:0]  count;
  logic [N-1:0]   valid_vec;

  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_vec[i] = CW'(i) < count;
    end
  end

  // ---------------------------------------------------------------- cell chain
  skl_pkg::key_t       cell_key [N];
  skl_pkg::cell_ctrl_t ctrl     [N];
  logic [N-1:0]        eq_vec;
  logic [N-1:0]        gt_raw;

  for (genvar g = 0; g < N; g++) begin : g_cell
    skl_pkg::key_t prev_k;
    skl_pkg::key_t next_k;
    if (g == 0) begin : g_lo
      assign prev_k = cell_key[g];
    end else begin : g_mid_lo
      assign prev_k = cell_key[g-1];
    end
    if (g == N - 1) begin : g_hi
      assign next_k = cell_key[g];
    end else begin : g_mid_hi
      assign next_k = cell_key[g+1];
    end
    skl_cell u_cell (
      .clk      (clk),
      .cmp_en   (accept),
      .valid    (valid_vec[g]),
      .cmd_key  (accept ? cmd.key : cmd_q.key),
      .prev_key (prev_k),
      .next_key (next_k),
      .ctrl     (ctrl[g]),
      .key      (cell_key[g]),
      .eq       (eq_vec[g]),
      .gt       (gt_raw[g])
    );
  end

  // ---------------------------------------------------------------- update
  logic [N-1:0]   one_n;
  logic [N-1:0]   gt_vec;
  logic [N-1:0]   eq_neg, gt_neg;
  logic [N-1:0]   eq_first, gt_first;   // lowest set flag, one-hot
  logic [N-1:0]   eq_from, gt_from;     // lowest set flag and everything above
  logic [N-1:0]   tail_hot;             // one-hot at the current count
  logic [PW-1:0]  eq_pos, gt_pos;
  logic           eq_any, gt_any, full;
  logic [N-1:0]   wr_vec, up_vec, down_vec;
  skl_pkg::result_t result_next;
  logic [CW-1:0]  count_next;

  assign one_n    = {{(N-1){1'b0}}, 1'b1};
  assign gt_vec   = ordered ? gt_raw : '0;
  assign eq_neg   = ~eq_vec + one_n;
  assign gt_neg   = ~gt_vec + one_n;
  assign eq_first = eq_vec & eq_neg;
  assign gt_first = gt_vec & gt_neg;
  assign eq_from  = eq_vec | eq_neg;
  assign gt_from  = gt_vec | gt_neg;
  assign eq_any   = |eq_vec;
  assign gt_any   = |gt_vec;
  assign full     = count == CW'(N);

  always_comb begin
    eq_pos = '0;
    gt_pos = '0;
    for (int i = 0; i < N; i++) begin
      tail_hot[i] = CW'(i) == count;
      if (eq_first[i]) eq_pos = eq_pos | PW'(i);
      if (gt_first[i]) gt_pos = gt_pos | PW'(i);
    end
  end

  always_comb begin
    wr_vec      = '0;
    up_vec      = '0;
    down_vec    = '0;
    count_next  = count;
    result_next = '0;
    result_next.count = count;
    unique case (skl_pkg::mode_t'(cmd_q.mode))
      skl_pkg::MODE_INSERT: begin
        if (full) begin
          result_next.status = skl_pkg::ST_FULL;
        end else begin
          // Insert before the first greater key (ordered mode only), else at the tail
          wr_vec = gt_any ? gt_first : tail_hot;
          up_vec = {gt_from[N-2:0], 1'b0};
          count_next = count + CW'(1);
          result_next.status   = skl_pkg::ST_OK;
          result_next.position = gt_any ? gt_pos : count[PW-1:0];
          result_next.key_out  = cmd_q.key;
          result_next.count    = count_next;
        end
      end
      skl_pkg::MODE_REMOVE, skl_pkg::MODE_SEARCH: begin
        if (count == '0) begin
          result_next.status = skl_pkg::ST_EMPTY;
        end else if (!eq_any) begin
          result_next.status = skl_pkg::ST_NOT_FOUND;
        end else begin
          if (cmd_q.mode == skl_pkg::MODE_REMOVE) begin
            // Close the gap: the match and all cells above take the upper neighbor
            down_vec   = eq_from;
            count_next = count - CW'(1);
          end
          result_next.status   = skl_pkg::ST_OK;
          result_next.position = eq_pos;
          result_next.key_out  = cmd_q.key;
          result_next.count    = count_next;
        end
      end
      skl_pkg::MODE_RESERVED: begin
        result_next.status = skl_pkg::ST_OK;
      end
      default: begin
        result_next.status = skl_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctrl[i].wr   = busy && wr_vec[i];
      ctrl[i].up   = busy && up_vec[i];
      ctrl[i].down = busy && down_vec[i];
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
      ordered <= 1'b0;
    end else begin
      done <= busy;
      if (accept) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy  <= 1'b0;
        count <= count_next;
      end
      if (cfg_wr && paddr[2] == skl_pkg::REG_ORDERED) begin
        ordered <= pwdata[0];
      end
    end
  end

  // Payload: hold the command, load the result in the update cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (busy) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
